// ===== rtl/byte_stuff_framer_crc16_core_defines.svh =====
// ----------------------------------------------------------------------------
// byte_stuff_framer_crc16_core_defines.svh
// Assertion macros for the byte stuffing framer, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef BYTE_STUFF_FRAMER_CRC16_CORE_DEFINES_SVH
`define BYTE_STUFF_FRAMER_CRC16_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define BSF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("framer assertion failed");
// next-cycle implication, checked out of reset
`define BSF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("framer assertion failed");
`else
`define BSF_ASSERT_NOW(label, ante, cons)
`define BSF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/bsf_crc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsf_crc_pkg
// Constants, byte select type and crc update function for the framer
// ----------------------------------------------------------------------------
package bsf_crc_pkg;

  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [15:0] CRC_MASK  = 16'hFFFF;
  localparam logic [15:0] CRC_RESET = 16'hFFFF;

  // which byte of the held transaction is being sent
  typedef enum logic [2:0] {
    SEL_DATA = 3'b001,
    SEL_LO   = 3'b010,
    SEL_HI   = 3'b100
  } sel_t;

  // reflected crc-16, one byte folded in lsb first
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/byte_stuff_framer_crc16_core.sv =====
// ----------------------------------------------------------------------------
// byte_stuff_framer_crc16_core
// Byte stuffing framer: passes payload bytes through, appends the inverted
// reflected crc-16 after the last byte, escapes 0x7D/0x7E as 0x7D, byte^0x20
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in      | input     | in_valid/in_ready   | in_data_byte, in_frame_end
//  out     | output    | out_valid/out_ready | out_byte, out_item_last,
//          |           |                     | out_frame_last
//  cfg     | input     | cfg_we              | cfg_wdata (crc seed)
//
//  One output byte per cycle from the output register. A transaction makes 1
//  to 6 output bytes, held in the byte sequencer until the last one is sent;
//  a plain byte with no frame end sustains one transaction per cycle.
//  The crc is updated in the accepting cycle; a new transaction is taken in
//  the cycle the held one sends its last byte. Out stalls hold the output
//  register and, through it, the sequencer and in_ready.
//  Reset is synchronous: seed and crc return to 0xFFFF, no bytes pending.
// ----------------------------------------------------------------------------
`include "byte_stuff_framer_crc16_core_defines.svh"

module byte_stuff_framer_crc16_core
  import bsf_crc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_item_last,
  output logic        out_frame_last,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] seed_r;
  logic [15:0] crc_r;
  logic [15:0] crc_nxt;

  // held transaction
  logic        item_valid_r;
  logic [7:0]  item_data_r;
  logic [15:0] item_fcs_r;
  logic        item_end_r;
  sel_t        item_sel_r;
  logic        item_esc_r;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_item_last_r;
  logic        out_frame_last_r;

  logic [7:0]  cur_byte;
  logic        cur_needs_esc;
  logic        byte_done;
  logic [7:0]  emit_byte;
  logic        emit_item_last;
  logic        emit_frame_last;
  logic        load_out;
  logic        advance;
  logic        in_accept;
  logic [15:0] fold_w;

  // seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= CRC_RESET;
    end else if (cfg_we) begin
      seed_r <= cfg_wdata;
    end
  end

  // crc update on accept, reload from seed at frame end
  assign fold_w = crc_fold(crc_r, in_data_byte);

  always_comb begin
    crc_nxt = crc_r;
    if (in_accept) begin
      crc_nxt = in_frame_end ? seed_r : fold_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_RESET;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  // current byte of the held transaction and its escaping
  always_comb begin
    unique case (item_sel_r)
      SEL_DATA: cur_byte = item_data_r;
      SEL_LO:   cur_byte = item_fcs_r[7:0];
      SEL_HI:   cur_byte = item_fcs_r[15:8];
      default:  cur_byte = item_data_r;
    endcase
  end

  assign cur_needs_esc   = (cur_byte == ESC_BYTE) || (cur_byte == FLAG_BYTE);
  assign byte_done       = !(cur_needs_esc && !item_esc_r);
  assign emit_byte       = !byte_done ? ESC_BYTE :
                           (cur_needs_esc ? (cur_byte ^ ESC_XOR) : cur_byte);
  assign emit_frame_last = byte_done && (item_sel_r == SEL_HI);
  assign emit_item_last  = byte_done &&
                           ((item_sel_r == SEL_HI) ||
                            ((item_sel_r == SEL_DATA) && !item_end_r));

  // handshake
  assign load_out  = !out_valid_r || out_ready;
  assign advance   = item_valid_r && load_out;
  assign in_ready  = !item_valid_r || (advance && emit_item_last);
  assign in_accept = in_valid && in_ready;

  // byte sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      item_sel_r   <= SEL_DATA;
      item_esc_r   <= 1'b0;
    end else if (in_accept) begin
      item_valid_r <= 1'b1;
      item_sel_r   <= SEL_DATA;
      item_esc_r   <= 1'b0;
    end else if (advance) begin
      if (!byte_done) begin
        item_esc_r <= 1'b1;
      end else if (emit_item_last) begin
        item_valid_r <= 1'b0;
      end else begin
        item_esc_r <= 1'b0;
        unique case (item_sel_r)
          SEL_DATA: item_sel_r <= SEL_LO;
          SEL_LO:   item_sel_r <= SEL_HI;
          SEL_HI:   item_sel_r <= SEL_HI;
          default:  item_sel_r <= SEL_DATA;
        endcase
      end
    end
  end

  // transaction payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_data_r <= in_data_byte;
      item_fcs_r  <= fold_w ^ CRC_MASK;
      item_end_r  <= in_frame_end;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_byte_r       <= emit_byte;
      out_item_last_r  <= emit_item_last;
      out_frame_last_r <= emit_frame_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_item_last  = out_item_last_r;
  assign out_frame_last = out_frame_last_r;

  // checks
  `BSF_ASSERT_NOW(a_frame_last_ends_item, out_valid_r && out_frame_last_r, out_item_last_r)
  `BSF_ASSERT_NOW(a_escape_not_last, out_valid_r && out_byte_r == ESC_BYTE, !out_item_last_r)
  `BSF_ASSERT_NOW(a_esc_phase_needs_esc, item_valid_r && item_esc_r, cur_needs_esc)
  `BSF_ASSERT_NEXT(a_crc_reload, in_accept && in_frame_end, crc_r == $past(seed_r))

endmodule
